// ===== sv/whp_pkg.sv =====
// ----------------------------------------------------------------------------
// whp_pkg
// Types, constants and helper functions shared by the MAC header parser.
// ----------------------------------------------------------------------------
package whp_pkg;

   // frame type codes
   localparam logic [1:0] FT_MGMT = 2'd0;
   localparam logic [1:0] FT_CTRL = 2'd1;
   localparam logic [1:0] FT_DATA = 2'd2;

   // control subtypes
   localparam logic [3:0] SUB_RTS    = 4'd11;
   localparam logic [3:0] SUB_BA_REQ = 4'd8;
   localparam logic [3:0] SUB_BA_RSP = 4'd9;

   // header lengths in bytes
   localparam logic [5:0] LEN_MGMT     = 6'd24;
   localparam logic [5:0] LEN_RTS      = 6'd16;
   localparam logic [5:0] LEN_CTRL     = 6'd10;
   localparam logic [5:0] LEN_DATA     = 6'd24;
   localparam logic [5:0] LEN_ADDR4    = 6'd6;
   localparam logic [5:0] LEN_QOS      = 6'd2;

   // byte offsets where each field ends
   localparam logic [5:0] END_CTL  = 6'd2;
   localparam logic [5:0] END_DUR  = 6'd4;
   localparam logic [5:0] END_A1   = 6'd10;
   localparam logic [5:0] END_A2   = 6'd16;
   localparam logic [5:0] END_A3   = 6'd22;
   localparam logic [5:0] END_SEQ  = 6'd24;
   localparam logic [5:0] END_A4   = 6'd30;

   // field select codes
   localparam logic [2:0] FLD_CTL = 3'd0;
   localparam logic [2:0] FLD_DUR = 3'd1;
   localparam logic [2:0] FLD_A1  = 3'd2;
   localparam logic [2:0] FLD_A2  = 3'd3;
   localparam logic [2:0] FLD_A3  = 3'd4;
   localparam logic [2:0] FLD_SEQ = 3'd5;
   localparam logic [2:0] FLD_A4  = 3'd6;
   localparam logic [2:0] FLD_QOS = 3'd7;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [15:0] fc_word;
      logic [15:0] duration_id;
      logic [47:0] address_one;
      logic [47:0] address_two;
      logic [47:0] address_three;
      logic [47:0] address_four;
      logic [3:0]  fragment_number;
      logic [11:0] sequence_number;
      logic [15:0] qos_word;
      logic [5:0]  header_bytes;
      logic        parse_status;
   } rsp_type;

   // one classified byte on its way from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic [2:0] field;
      logic       start;
      logic       last;
      logic [5:0] header_bytes;
      logic       parse_status;
   } op_type;

   function automatic logic both_ds(input logic [15:0] fc);
      return fc[9:8] == 2'b11;
   endfunction

   function automatic logic [5:0] hdr_len(input logic [15:0] fc);
      logic [5:0] len;
      len = LEN_CTRL;
      case (fc[3:2])
         FT_MGMT: len = LEN_MGMT;
         FT_CTRL: len = (fc[7:4] == SUB_RTS) ? LEN_RTS : LEN_CTRL;
         FT_DATA: begin
            len = LEN_DATA;
            if (both_ds(fc)) len = len + LEN_ADDR4;
            if (fc[7]) len = len + LEN_QOS;
         end
         default: len = LEN_CTRL;
      endcase
      return len;
   endfunction

   function automatic logic hdr_unsupported(input logic [15:0] fc);
      return (fc[3:2] == FT_CTRL) &&
             ((fc[7:4] == SUB_BA_REQ) || (fc[7:4] == SUB_BA_RSP));
   endfunction

   function automatic logic [2:0] field_sel(input logic [5:0] idx, input logic ds);
      logic [2:0] f;
      if (idx < END_CTL)           f = FLD_CTL;
      else if (idx < END_DUR)      f = FLD_DUR;
      else if (idx < END_A1)       f = FLD_A1;
      else if (idx < END_A2)       f = FLD_A2;
      else if (idx < END_A3)       f = FLD_A3;
      else if (idx < END_SEQ)      f = FLD_SEQ;
      else if (ds && idx < END_A4) f = FLD_A4;
      else                         f = FLD_QOS;
      return f;
   endfunction

endpackage

// ===== sv/whp_front.sv =====
// ----------------------------------------------------------------------------
// whp_front
// Accepts frame bytes, tracks the byte position and frame control, and tags
// each byte with its target field and an end-of-header flag.
// ----------------------------------------------------------------------------
module whp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  whp_pkg::req_type req_data,
   output logic             op_valid,
   output whp_pkg::op_type  op_data
);
   import whp_pkg::*;

   logic        active_ff, active_in;
   logic [5:0]  idx_ff, idx_in;
   logic [15:0] fc_ff, fc_in;

   logic        eff_active;
   logic [5:0]  eff_idx;
   logic [15:0] cur_fc;
   logic [5:0]  len;
   logic        last;

   // position of this byte, a start byte always opens a header
   assign eff_active = req_data.frame_start | active_ff;
   assign eff_idx    = req_data.frame_start ? 6'd0 : idx_ff;

   // frame control as known once this byte is in
   assign cur_fc = (eff_idx < END_CTL) ? {fc_ff[7:0], req_data.data_byte} : fc_ff;
   assign len    = hdr_len(cur_fc);
   assign last   = (eff_idx != 6'd0) && ((eff_idx + 6'd1) == len);

   // classified item toward the queue
   assign op_valid             = fire & eff_active;
   assign op_data.data_byte    = req_data.data_byte;
   assign op_data.field        = field_sel(eff_idx, both_ds(cur_fc));
   assign op_data.start        = req_data.frame_start;
   assign op_data.last         = last;
   assign op_data.header_bytes = len;
   assign op_data.parse_status = hdr_unsupported(cur_fc);

   // position and frame control tracking
   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      fc_in     = fc_ff;
      if (op_valid) begin
         active_in = ~last;
         idx_in    = eff_idx + 6'd1;
         if (eff_idx < END_CTL) fc_in = cur_fc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= 6'd0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
      fc_ff <= fc_in;
   end

endmodule

// ===== sv/whp_queue.sv =====
// ----------------------------------------------------------------------------
// whp_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module whp_queue #(
   parameter int DEPTH = whp_pkg::QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  whp_pkg::op_type push_data,
   input  logic            pop,
   output logic            full,
   output logic            not_empty,
   output whp_pkg::op_type head_data
);
   import whp_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   op_type         slot_ff [DEPTH];
   logic [PW-1:0]  wr_ff, wr_in;
   logic [PW-1:0]  rd_ff, rd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_data = slot_ff[rd_ff];

   // pointer and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      if (push && !pop)      cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= push_data;
   end

endmodule

// ===== sv/whp_back.sv =====
// ----------------------------------------------------------------------------
// whp_back
// Shifts classified bytes into the header field registers and loads the
// result register when the last header byte is taken.
// ----------------------------------------------------------------------------
module whp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_ready,
   input  whp_pkg::op_type  op_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output whp_pkg::rsp_type rsp_data
);
   import whp_pkg::*;

   logic [15:0] ctl_ff, ctl_in, dur_ff, dur_in, seq_ff, seq_in, qos_ff, qos_in;
   logic [47:0] a1_ff, a1_in, a2_ff, a2_in, a3_ff, a3_in, a4_ff, a4_in;
   logic [15:0] ctl_base, dur_base, seq_base, qos_base;
   logic [47:0] a1_base, a2_base, a3_base, a4_base;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic        out_free;

   // a result item may only be loaded when the output register is empty or drains
   assign out_free = ~out_valid_ff | ~rsp_stall;
   assign pop      = op_ready & (~op_data.last | out_free);

   // start of a header clears every field
   always_comb begin
      ctl_base = op_data.start ? '0 : ctl_ff;
      dur_base = op_data.start ? '0 : dur_ff;
      seq_base = op_data.start ? '0 : seq_ff;
      qos_base = op_data.start ? '0 : qos_ff;
      a1_base  = op_data.start ? '0 : a1_ff;
      a2_base  = op_data.start ? '0 : a2_ff;
      a3_base  = op_data.start ? '0 : a3_ff;
      a4_base  = op_data.start ? '0 : a4_ff;
   end

   // shift the byte into its field
   always_comb begin
      ctl_in = ctl_base;
      dur_in = dur_base;
      seq_in = seq_base;
      qos_in = qos_base;
      a1_in  = a1_base;
      a2_in  = a2_base;
      a3_in  = a3_base;
      a4_in  = a4_base;
      case (op_data.field)
         FLD_CTL: ctl_in = {ctl_base[7:0], op_data.data_byte};
         FLD_DUR: dur_in = {dur_base[7:0], op_data.data_byte};
         FLD_A1:  a1_in  = {a1_base[39:0], op_data.data_byte};
         FLD_A2:  a2_in  = {a2_base[39:0], op_data.data_byte};
         FLD_A3:  a3_in  = {a3_base[39:0], op_data.data_byte};
         FLD_SEQ: seq_in = {seq_base[7:0], op_data.data_byte};
         FLD_A4:  a4_in  = {a4_base[39:0], op_data.data_byte};
         FLD_QOS: qos_in = {qos_base[7:0], op_data.data_byte};
         default: ctl_in = ctl_base;
      endcase
   end

   // result item assembled from the updated fields
   always_comb begin
      out_in.fc_word         = ctl_in;
      out_in.duration_id     = dur_in;
      out_in.address_one     = a1_in;
      out_in.address_two     = a2_in;
      out_in.address_three   = a3_in;
      out_in.address_four    = a4_in;
      out_in.fragment_number = seq_in[3:0];
      out_in.sequence_number = seq_in[15:4];
      out_in.qos_word        = qos_in;
      out_in.header_bytes    = op_data.header_bytes;
      out_in.parse_status    = op_data.parse_status;
   end

   // output valid tracking
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      if (pop && op_data.last)        out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (pop) begin
         ctl_ff <= ctl_in;
         dur_ff <= dur_in;
         seq_ff <= seq_in;
         qos_ff <= qos_in;
         a1_ff  <= a1_in;
         a2_ff  <= a2_in;
         a3_ff  <= a3_in;
         a4_ff  <= a4_in;
      end
      if (pop && op_data.last) out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== sv/wlan_mac_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// wlan_mac_header_parser_unit
// Parses a wireless MAC header from a byte stream and gives one result item
// per complete header.
// ----------------------------------------------------------------------------
// Usage: the req channel takes one frame byte per item, with frame_start set
// on the first header byte. Bytes outside a header (before any start or after
// the header end) are dropped. A start in mid-header drops the partial header.
// When the last header byte (10 to 32 bytes in) is taken, one item with all
// header fields appears on the rsp channel; absent fields read zero.
// Throughput: one byte per cycle while req_stall is low, set by the front
// classifier and the back field registers each handling one byte a cycle.
// Path: the last header byte is written into the queue, then loaded into the
// back result register when popped, once that register is empty or drains.
// Reset (synchronous) empties the queue, drops any result item and leaves the
// parser idle until the next start byte.
// Stall: a held result item blocks the back only at the next header end;
// bytes keep flowing into the queue, and req_stall rises once it is full.
// ----------------------------------------------------------------------------
module wlan_mac_header_parser_unit #(
   parameter int QUEUE_DEPTH = whp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  whp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output whp_pkg::rsp_type rsp_data
);
   import whp_pkg::*;

   logic   fire;
   logic   op_valid;
   op_type op_data;
   logic   q_full;
   logic   q_not_empty;
   logic   q_pop;
   op_type q_head;

   assign fire      = req_valid & ~req_stall;
   assign req_stall = q_full;

   // front: classify incoming bytes
   whp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req_data (req_data),
      .op_valid (op_valid),
      .op_data  (op_data)
   );

   // queue between front and back
   whp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_valid),
      .push_data (op_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_data (q_head)
   );

   // back: build fields and the result item
   whp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_ready  (q_not_empty),
      .op_data   (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
